// ===== hw/rtl/kbs_pkg.sv =====
`timescale 1ns / 1ps

package kbs_pkg;

   localparam int KBS_HASH_W     = 64;
   localparam int KBS_INDEX_W    = 32;
   localparam int KBS_LEN_W      = 8;
   localparam int KBS_QUEUE_DEPTH = 2;
   localparam int KBS_STEP_W     = $clog2(KBS_HASH_W);

   localparam logic [KBS_HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [KBS_HASH_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [KBS_HASH_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
   localparam int                    MIX_SHIFT = 33;
   localparam int                    LEN_SHIFT = 56;
   localparam logic [KBS_LEN_W-1:0]  SMALL_KEY_BYTES = 8'd8;

   localparam logic [KBS_STEP_W-1:0] MUL_STEP_LAST = 6'd2;
   localparam logic [KBS_STEP_W-1:0] DIV_STEP_LAST = 6'(KBS_HASH_W - 1);

   typedef struct packed {
      logic [7:0] key_byte;
      logic       last_byte;
   } kbs_req_type;

   typedef struct packed {
      logic [KBS_HASH_W-1:0]  hash_value;
      logic [KBS_INDEX_W-1:0] bucket_index;
   } kbs_rsp_type;

   typedef struct packed {
      logic                  push;
      logic [KBS_HASH_W-1:0] seed;
   } kbs_seed_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV,
      ST_HOLD
   } back_state_type;

   function automatic logic [KBS_HASH_W-1:0] xor_shift(input logic [KBS_HASH_W-1:0] h);
      return h ^ (h >> MIX_SHIFT);
   endfunction

endpackage

// ===== hw/rtl/kbs_front.sv =====
`timescale 1ns / 1ps

module kbs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  kbs_pkg::kbs_req_type req_word,
   output kbs_pkg::kbs_seed_type seed_out
);
   import kbs_pkg::*;

   logic [KBS_HASH_W-1:0] fnv_ff, fnv_in;
   logic [KBS_HASH_W-1:0] packed_ff, packed_in;
   logic [KBS_LEN_W-1:0]  len_ff, len_in;
   logic                  long_ff, long_in;

   logic [KBS_HASH_W-1:0] fnv_x;
   logic [KBS_HASH_W-1:0] fnv_next;
   logic [KBS_HASH_W-1:0] packed_next;
   logic [KBS_LEN_W-1:0]  len_next;
   logic                  long_next;
   logic [KBS_HASH_W-1:0] selected;

   // The FNV prime is 2^40 + 0x1b3, so the multiply is a sum of shifted copies.
   always_comb begin
      fnv_x    = fnv_ff ^ {56'd0, req_word.key_byte};
      fnv_next = fnv_x + (fnv_x << 1) + (fnv_x << 4) + (fnv_x << 5)
               + (fnv_x << 7) + (fnv_x << 8) + (fnv_x << 40);

      packed_next = packed_ff;
      long_next   = long_ff;
      if (!long_ff && (len_ff < SMALL_KEY_BYTES)) begin
         packed_next[len_ff[2:0]*8 +: 8] = packed_ff[len_ff[2:0]*8 +: 8] | req_word.key_byte;
      end else begin
         long_next = 1'b1;
      end
      len_next = len_ff + 8'd1;

      selected = long_next ? fnv_next : packed_next;

      seed_out.push = req_accept && req_word.last_byte;
      seed_out.seed = selected ^ ({56'd0, len_next} << LEN_SHIFT);

      fnv_in    = fnv_ff;
      packed_in = packed_ff;
      len_in    = len_ff;
      long_in   = long_ff;
      if (req_accept) begin
         if (req_word.last_byte) begin
            fnv_in    = FNV_BASIS;
            packed_in = '0;
            len_in    = '0;
            long_in   = 1'b0;
         end else begin
            fnv_in    = fnv_next;
            packed_in = packed_next;
            len_in    = len_next;
            long_in   = long_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fnv_ff    <= FNV_BASIS;
         packed_ff <= '0;
         len_ff    <= '0;
         long_ff   <= 1'b0;
      end else begin
         fnv_ff    <= fnv_in;
         packed_ff <= packed_in;
         len_ff    <= len_in;
         long_ff   <= long_in;
      end
   end

endmodule

// ===== hw/rtl/kbs_queue.sv =====
`timescale 1ns / 1ps

module kbs_queue #(
   parameter int DEPTH = kbs_pkg::KBS_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kbs_pkg::kbs_seed_type         wr,
   output logic                          full,
   input  logic                          pop,
   output logic                          empty,
   output logic [kbs_pkg::KBS_HASH_W-1:0] rd_data
);
   import kbs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [KBS_HASH_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = (count_ff == CNT_FULL);
      empty   = (count_ff == '0);
      rd_data = slot_ff[rd_ptr_ff];
      do_push = wr.push && !full;
      do_pop  = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr.seed;
      end
   end

endmodule

// ===== hw/rtl/kbs_back.sv =====
`timescale 1ns / 1ps

module kbs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [kbs_pkg::KBS_INDEX_W-1:0] bucket_count,
   input  logic                           q_empty,
   input  logic [kbs_pkg::KBS_HASH_W-1:0]  q_data,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output kbs_pkg::kbs_rsp_type           rsp_word
);
   import kbs_pkg::*;

   back_state_type state_ff, state_in;
   logic [KBS_STEP_W-1:0]  step_ff, step_in;
   logic                   out_valid_ff, out_valid_in;
   logic [KBS_HASH_W-1:0]  h_ff, h_in;
   logic [KBS_HASH_W-1:0]  acc_ff, acc_in;
   logic [KBS_INDEX_W-1:0] rem_ff, rem_in;
   kbs_rsp_type            out_ff, out_in;

   logic [KBS_HASH_W-1:0]  mul_const;
   logic [31:0]            op_a, op_b;
   logic [63:0]            prod;
   logic [KBS_HASH_W-1:0]  mul_done;
   logic [KBS_INDEX_W:0]   trial;
   logic [KBS_INDEX_W:0]   diff;

   // One 32 by 32 multiplier builds the low 64 bits of each 64 by 64 product over three steps.
   always_comb begin
      mul_const = (state_ff == ST_MUL_B) ? MIX_MUL_B : MIX_MUL_A;
      op_a      = (step_ff == MUL_STEP_LAST) ? h_ff[63:32] : h_ff[31:0];
      op_b      = (step_ff == 6'd1) ? mul_const[63:32] : mul_const[31:0];
      prod      = op_a * op_b;
      mul_done  = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
      trial     = {rem_ff, acc_ff[KBS_HASH_W-1]};
      diff      = trial - {1'b0, bucket_count};
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      h_in         = h_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      out_in       = out_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               h_in     = xor_shift(q_data);
               step_in  = '0;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A, ST_MUL_B: begin
            if (step_ff == '0) begin
               acc_in  = prod;
               step_in = step_ff + 1'b1;
            end else if (step_ff != MUL_STEP_LAST) begin
               acc_in  = mul_done;
               step_in = step_ff + 1'b1;
            end else begin
               h_in = xor_shift(mul_done);
               if (state_ff == ST_MUL_A) begin
                  step_in  = '0;
                  state_in = ST_MUL_B;
               end else begin
                  acc_in   = xor_shift(mul_done);
                  rem_in   = '0;
                  step_in  = DIV_STEP_LAST;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!diff[KBS_INDEX_W]) begin
               rem_in = diff[KBS_INDEX_W-1:0];
            end else begin
               rem_in = trial[KBS_INDEX_W-1:0];
            end
            acc_in = acc_ff << 1;
            if (step_ff == '0) begin
               state_in = ST_HOLD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_HOLD: begin
            if (!out_valid_ff || rsp_pop) begin
               out_in.hash_value   = h_ff;
               out_in.bucket_index = (bucket_count == '0) ? '0 : rem_ff;
               out_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_empty = !out_valid_ff;
      rsp_word  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff   <= h_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      out_ff <= out_in;
   end

endmodule

// ===== hw/rtl/key_hash_bucket_select_core.sv =====
`timescale 1ns / 1ps

// Streaming key hash with bucket selection.
// Key bytes enter on the request queue port, one word per cycle, with last_byte set on the
// final byte of each key. A word is taken when req_push is high and req_full is low.
// Each finished key yields one result word (hash_value, bucket_index) on the response port;
// it is valid while rsp_empty is low and is taken when rsp_pop is high.
// The byte front end accepts a word every cycle while req_full is low. A finished key waits
// in a small queue, then the back end runs the avalanche mix on one shared 32 by 32 multiplier
// and the remainder with a one-bit-per-cycle divider. The back end takes the next key from
// the queue only after it has handed the previous result to the response register.
// When the queue is full, req_full rises until the back end frees a slot.
// If the receiver stalls, the result is held on the response port and the back end waits
// with the next result; the front end keeps taking bytes until the queue fills.
// The bucket count is written through csr_write_en and csr_write_data; the user must do so
// only while the block is idle (not enforced); a count of zero gives a bucket index of zero.
// Reset is synchronous: it empties the queue and the result register, restarts the key
// state and sets the bucket count to one.
module key_hash_bucket_select_core #(
   parameter int QUEUE_DEPTH = kbs_pkg::KBS_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  kbs_pkg::kbs_req_type           req_word,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output kbs_pkg::kbs_rsp_type           rsp_word,
   input  logic                           csr_write_en,
   input  logic [kbs_pkg::KBS_INDEX_W-1:0] csr_write_data
);
   import kbs_pkg::*;

   logic [KBS_INDEX_W-1:0] bucket_count_ff, bucket_count_in;
   logic                   req_accept;
   kbs_seed_type           seed;
   logic                   q_empty, q_pop;
   logic [KBS_HASH_W-1:0]  q_data;

   always_comb begin
      req_accept      = req_push && !req_full;
      bucket_count_in = csr_write_en ? csr_write_data : bucket_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= 32'd1;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   kbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_word   (req_word),
      .seed_out   (seed)
   );

   kbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (seed),
      .full    (req_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_data)
   );

   kbs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .bucket_count (bucket_count_ff),
      .q_empty      (q_empty),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_word     (rsp_word)
   );

endmodule
